// ----- rtl/sru_pkg.sv -----
// ----------------------------------------------------------------------------
// sru_pkg
// Shared widths, types, lookup tables and fixed-point helpers of the simple
// recurrent unit lane.
// ----------------------------------------------------------------------------
package sru_pkg;

   localparam int DATA_WIDTH  = 16;
   localparam int TABLE_DEPTH = 256;
   localparam int FRAC_BITS   = 12;
   localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);
   localparam int GATE_W      = FRAC_BITS + 2;
   localparam int TAB_IDX_W   = $clog2(TABLE_DEPTH);
   localparam int TAB_IN_W    = 16;
   localparam int TAB_IN_MAX  = (1 << (TAB_IN_W - 1)) - 1;
   localparam int TAB_IN_MIN  = -(1 << (TAB_IN_W - 1));
   localparam int CLAMP_W     = (DATA_WIDTH > TAB_IN_W) ? DATA_WIDTH : TAB_IN_W;
   localparam int SAT_W       = DATA_WIDTH + GATE_W + 4;
   localparam longint DATA_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
   localparam longint DATA_MIN = -(longint'(1) << (DATA_WIDTH - 1));

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam int REQ_DATA_W  = ((4 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int CSR_IDX_W   = 2;

   localparam longint Q28_ONE = longint'(1) << 28;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [GATE_W-1:0]     gate_type;
   typedef gate_type                     tab_type [TABLE_DEPTH];

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORGET_BIAS   = 2'd0,
      CSR_RESET_BIAS    = 2'd1,
      CSR_MASK_VALUE    = 2'd2,
      CSR_INITIAL_STATE = 2'd3
   } csr_index_type;

   typedef struct packed {
      data_type forget_bias;
      data_type reset_bias;
      data_type mask_value;
      data_type initial_state;
   } cfg_type;

   typedef struct packed {
      data_type candidate;
      data_type sample;
      logic     first_step;
      gate_type ft;
      gate_type rt;
   } entry_type;

   // Shift-subtract division, evaluated only while the tables are built.
   function automatic longint unsigned tab_udiv(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-a/4096) in Q28 by a Taylor series at a reduced argument, then squaring.
   function automatic longint tab_exp_neg(input longint a, input int s);
      longint dv;
      longint sum;
      longint term;
      dv   = longint'(4096) << s;
      sum  = Q28_ONE;
      term = Q28_ONE;
      for (int k = 1; k <= 14; k++) begin
         term = longint'(tab_udiv(longint'(term * a), longint'(dv * k)));
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      for (int j = 0; j < s; j++) begin
         sum = (sum * sum) >>> 28;
      end
      return sum;
   endfunction

   function automatic tab_type build_sig_tab();
      tab_type t;
      longint  x;
      longint  a;
      longint  e;
      longint  den;
      longint  p;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         x   = (longint'(2 * i + 1) * 32768) / TABLE_DEPTH - 32768;
         a   = (x < 0) ? -x : x;
         e   = tab_exp_neg(a, 3);
         den = Q28_ONE + e;
         p   = longint'(tab_udiv((longint'(1) << 40) + (den >>> 1), den));
         t[i] = GATE_W'((x >= 0) ? p : (4096 - p));
      end
      return t;
   endfunction

   function automatic tab_type build_tanh_tab();
      tab_type t;
      longint  x;
      longint  a;
      longint  e;
      longint  den;
      longint  p;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         x   = (longint'(2 * i + 1) * 32768) / TABLE_DEPTH - 32768;
         a   = (x < 0) ? -x : x;
         e   = tab_exp_neg(2 * a, 4);
         den = Q28_ONE + e;
         p   = longint'(tab_udiv((Q28_ONE - e) * 4096 + (den >>> 1), den));
         t[i] = GATE_W'((x >= 0) ? p : -p);
      end
      return t;
   endfunction

   localparam tab_type SIG_TAB  = build_sig_tab();
   localparam tab_type TANH_TAB = build_tanh_tab();

   // Clamp to the table range and scale to a bin number.
   function automatic logic [TAB_IDX_W-1:0] tab_index(input data_type v);
      logic signed [CLAMP_W-1:0]          ve;
      logic [TAB_IN_W-1:0]                off;
      logic [TAB_IN_W+TAB_IDX_W-1:0]      scaled;
      ve = CLAMP_W'(v);
      if (ve > CLAMP_W'(TAB_IN_MAX)) begin
         ve = CLAMP_W'(TAB_IN_MAX);
      end else if (ve < CLAMP_W'(TAB_IN_MIN)) begin
         ve = CLAMP_W'(TAB_IN_MIN);
      end
      off    = {~ve[TAB_IN_W-1], ve[TAB_IN_W-2:0]};
      scaled = (TAB_IN_W + TAB_IDX_W)'(off) * (TAB_IN_W + TAB_IDX_W)'(TABLE_DEPTH);
      return scaled[TAB_IN_W+TAB_IDX_W-1:TAB_IN_W];
   endfunction

   function automatic data_type sat_data(input logic signed [SAT_W-1:0] v);
      data_type r;
      if (v > SAT_W'(DATA_MAX)) begin
         r = DATA_WIDTH'(DATA_MAX);
      end else if (v < SAT_W'(DATA_MIN)) begin
         r = DATA_WIDTH'(DATA_MIN);
      end else begin
         r = DATA_WIDTH'(v);
      end
      return r;
   endfunction

endpackage

// ----- rtl/sru_lane_recurrence_unit.sv -----
// ----------------------------------------------------------------------------
// sru_lane_recurrence_unit
// One lane of the simple recurrent unit over time: sigmoid gates, cell-state
// update and highway output, all in saturated Q4.12.
//
//   Channel  Direction  Accepted when             Contents
//   req_     in         req_tvalid & req_tready   projections, sample, first step
//   rsp_     out        rsp_tvalid & rsp_tready   hidden output, new cell state
//   csr_     in         csr_wr_en                 gate biases, mask, initial state
//
// A transaction is accepted every cycle while the output is taken; the cell
// state update (subtract, multiply by the forget gate, round, saturate) is
// combinational from the queue head and sets that rate. A request passes the
// queue, the s1 and s2 stage registers and the response register in that
// order. Reset empties the two-entry queue and all stages and clears the cell
// state. An output stall fills the stages, then the queue, and only then drops req_tready.
// ----------------------------------------------------------------------------
module sru_lane_recurrence_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // candidate_proj, forget_proj, reset_proj, sample_in
   input  logic [sru_pkg::REQ_DATA_W-1:0]       req_tdata,
   // first_step
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hidden_out, state_out
   output logic [sru_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic [sru_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sru_pkg::DATA_WIDTH-1:0]       csr_wdata
);
   import sru_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       q_full;
   logic       q_push;
   entry_type  push_entry;
   logic       q_pop;
   logic       q_valid;
   entry_type  head_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FORGET_BIAS:   cfg_in.forget_bias   = csr_wdata;
            CSR_RESET_BIAS:    cfg_in.reset_bias    = csr_wdata;
            CSR_MASK_VALUE:    cfg_in.mask_value    = csr_wdata;
            CSR_INITIAL_STATE: cfg_in.initial_state = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.forget_bias   <= '0;
         cfg_ff.reset_bias    <= '0;
         cfg_ff.mask_value    <= DATA_WIDTH'(1 << FRAC_BITS);
         cfg_ff.initial_state <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sru_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   sru_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   sru_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/sru_front.sv -----
// ----------------------------------------------------------------------------
// sru_front
// Accepts request transactions, adds the gate biases and looks up both gate
// sigmoids, then pushes the prepared item into the queue.
// ----------------------------------------------------------------------------
module sru_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sru_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  sru_pkg::cfg_type                  cfg,
   input  logic                              q_full,
   output logic                              q_push,
   output sru_pkg::entry_type                q_entry
);
   import sru_pkg::*;

   data_type candidate;
   data_type forget_proj;
   data_type reset_proj;
   data_type sample;
   data_type forget_pre;
   data_type reset_pre;

   assign candidate   = req_tdata[DATA_WIDTH-1:0];
   assign forget_proj = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
   assign reset_proj  = req_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
   assign sample      = req_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH];

   assign forget_pre = sat_data(SAT_W'(forget_proj) + SAT_W'(cfg.forget_bias));
   assign reset_pre  = sat_data(SAT_W'(reset_proj) + SAT_W'(cfg.reset_bias));

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_entry.candidate  = candidate;
      q_entry.sample     = sample;
      q_entry.first_step = req_tuser;
      q_entry.ft         = SIG_TAB[tab_index(forget_pre)];
      q_entry.rt         = SIG_TAB[tab_index(reset_pre)];
   end

endmodule

// ----- rtl/sru_queue.sv -----
// ----------------------------------------------------------------------------
// sru_queue
// Short FIFO of prepared items between the front and the recurrence back end.
// ----------------------------------------------------------------------------
module sru_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sru_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output sru_pkg::entry_type   head_entry
);
   import sru_pkg::*;

   entry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/sru_back.sv -----
// ----------------------------------------------------------------------------
// sru_back
// Recurrence back end: state update, masked tanh of the state, highway output
// and the response register.
// ----------------------------------------------------------------------------
module sru_back (
   input  logic                              clock,
   input  logic                              reset,
   input  sru_pkg::cfg_type                  cfg,
   input  logic                              q_valid,
   input  sru_pkg::entry_type                q_entry,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sru_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import sru_pkg::*;

   localparam int D1_W = DATA_WIDTH + 1;
   localparam int P1_W = D1_W + GATE_W;
   localparam int P2_W = GATE_W + DATA_WIDTH;
   localparam int M_W  = DATA_WIDTH + 2;
   localparam int H_W  = M_W + 1;
   localparam int P3_W = H_W + GATE_W;

   data_type                cell_ff;
   data_type                prev;
   logic signed [D1_W-1:0]  diff;
   logic signed [P1_W-1:0]  p1;
   logic signed [P1_W-1:0]  p1r;
   data_type                state_in;

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   data_type                s1_state_ff;
   data_type                s1_sample_ff;
   gate_type                s1_rt_ff;

   gate_type                th;
   logic signed [P2_W-1:0]  p2;
   logic signed [P2_W-1:0]  p2r;
   logic signed [M_W-1:0]   m_in;

   logic                    s2_valid_ff;
   logic                    s2_valid_in;
   logic signed [M_W-1:0]   s2_m_ff;
   data_type                s2_state_ff;
   data_type                s2_sample_ff;
   gate_type                s2_rt_ff;

   logic signed [H_W-1:0]   hd;
   logic signed [P3_W-1:0]  p3;
   logic signed [P3_W-1:0]  p3r;
   data_type                hidden_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   data_type                rsp_hidden_ff;
   data_type                rsp_state_ff;

   logic                    out_free;
   logic                    s2_adv;
   logic                    s2_free;
   logic                    s1_adv;
   logic                    s1_free;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s2_adv   = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || s2_adv;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_adv;
   assign q_pop    = q_valid && s1_free;

   always_comb begin
      prev     = q_entry.first_step ? cfg.initial_state : cell_ff;
      diff     = D1_W'(prev) - D1_W'(q_entry.candidate);
      p1       = P1_W'(diff) * P1_W'(q_entry.ft);
      p1r      = (p1 + P1_W'(ROUND_HALF)) >>> FRAC_BITS;
      state_in = sat_data(SAT_W'(p1r) + SAT_W'(q_entry.candidate));
   end

   always_comb begin
      th   = TANH_TAB[tab_index(s1_state_ff)];
      p2   = P2_W'(th) * P2_W'(cfg.mask_value);
      p2r  = (p2 + P2_W'(ROUND_HALF)) >>> FRAC_BITS;
      m_in = M_W'(p2r);
   end

   always_comb begin
      hd        = H_W'(s2_m_ff) - H_W'(s2_sample_ff);
      p3        = P3_W'(hd) * P3_W'(s2_rt_ff);
      p3r       = (p3 + P3_W'(ROUND_HALF)) >>> FRAC_BITS;
      hidden_in = sat_data(SAT_W'(p3r) + SAT_W'(s2_sample_ff));
   end

   always_comb begin
      s1_valid_in  = q_pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cell_ff <= state_in;
         end
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_state_ff  <= state_in;
         s1_sample_ff <= q_entry.sample;
         s1_rt_ff     <= q_entry.rt;
      end
      if (s1_adv) begin
         s2_m_ff      <= m_in;
         s2_state_ff  <= s1_state_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_rt_ff     <= s1_rt_ff;
      end
      if (s2_adv) begin
         rsp_hidden_ff <= hidden_in;
         rsp_state_ff  <= s2_state_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_state_ff, rsp_hidden_ff});

endmodule

// ----- rtl/sru_checker.sv -----
// ----------------------------------------------------------------------------
// sru_checker
// Port-level checks of the recurrence lane, bound to the top level.
// ----------------------------------------------------------------------------
module sru_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [sru_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import sru_pkg::*;

   localparam int MAX_IN_FLIGHT = QUEUE_DEPTH + 3;
   localparam int OUT_W         = $clog2(MAX_IN_FLIGHT + 1);

   logic [OUT_W-1:0] pending_ff;
   logic [OUT_W-1:0] pending_in;
   logic             req_xfer;
   logic             rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every response belongs to an accepted request.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != '0)
      else $error("response without a pending request");

   // The lane never holds more items than its queue and stages.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= OUT_W'(MAX_IN_FLIGHT))
      else $error("more items in flight than storage");

   // Reset leaves the lane empty and ready.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("lane not empty after reset");

endmodule

bind sru_lane_recurrence_unit sru_checker u_sru_checker (.*);

// ----- tb/sru_lane_recurrence_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sru_lane_recurrence_unit_tb
// Self-checking bench for one recurrent lane. Every accepted step goes through
// a lane model in the scoreboard class, which builds its own sigmoid and tanh
// tables and keeps its own cell state and register copy. Every result
// transaction is compared field by field against the oldest expected result.
// Directed steps cover the field and register extremes first. Random sequences
// follow under several register settings, with random idling on both streams
// and one long output stall.
// ----------------------------------------------------------------------------
import sru_pkg::*;

typedef struct {
   data_type candidate;
   data_type forget_proj;
   data_type reset_proj;
   data_type sample;
   logic     first_step;
} lane_step_type;

typedef struct {
   data_type hidden;
   data_type state;
} lane_result_type;

class lane_step_scoreboard;
   longint          sig_lut[TABLE_DEPTH];
   longint          tanh_lut[TABLE_DEPTH];
   data_type        forget_bias;
   data_type        reset_bias;
   data_type        mask_value;
   data_type        initial_state;
   data_type        cell_state;
   lane_result_type expected_results[$];
   int              errors;
   int              checked;
   int              seq_starts;
   int              gate_sat_count;
   int              state_sat_count;

   function new();
      longint one;
      longint x;
      longint a;
      longint e;
      longint den;
      longint p;
      one = longint'(1) << 28;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         x   = (longint'(2 * i + 1) * 32768) / TABLE_DEPTH - 32768;
         a   = (x < 0) ? -x : x;
         e   = decaying_exp(a, 3);
         den = one + e;
         p   = ((longint'(1) << 40) + den / 2) / den;
         sig_lut[i] = (x >= 0) ? p : 4096 - p;
         e   = decaying_exp(2 * a, 4);
         den = one + e;
         p   = ((one - e) * 4096 + den / 2) / den;
         tanh_lut[i] = (x >= 0) ? p : -p;
      end
      forget_bias   = '0;
      reset_bias    = '0;
      mask_value    = data_type'(4096);
      initial_state = '0;
      cell_state    = '0;
      errors        = 0;
      checked       = 0;
      seq_starts    = 0;
      gate_sat_count  = 0;
      state_sat_count = 0;
   endfunction

   // exp(-a/4096) in Q28: truncated Taylor series at a/2^sh, then squared sh times.
   function longint decaying_exp(longint a, int sh);
      longint dv;
      longint sum;
      longint term;
      dv   = longint'(4096) << sh;
      sum  = longint'(1) << 28;
      term = longint'(1) << 28;
      for (int k = 1; k <= 14; k++) begin
         term = (term * a) / (dv * k);
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      for (int j = 0; j < sh; j++) begin
         sum = (sum * sum) >>> 28;
      end
      return sum;
   endfunction

   function longint clip_q412(longint v);
      if (v > DATA_MAX) begin
         return DATA_MAX;
      end else if (v < DATA_MIN) begin
         return DATA_MIN;
      end
      return v;
   endfunction

   function longint round_q12(longint p);
      return (p + 2048) >>> 12;
   endfunction

   function int lut_bin(longint v);
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return int'(((v + 32768) * TABLE_DEPTH) >>> 16);
   endfunction

   function void set_reg(csr_index_type idx, data_type v);
      case (idx)
         CSR_FORGET_BIAS:   forget_bias   = v;
         CSR_RESET_BIAS:    reset_bias    = v;
         CSR_MASK_VALUE:    mask_value    = v;
         CSR_INITIAL_STATE: initial_state = v;
         default: ;
      endcase
   endfunction

   function void note_step(lane_step_type s);
      longint          fsum;
      longint          rsum;
      longint          fpre;
      longint          rpre;
      longint          prev;
      longint          ft;
      longint          rt;
      longint          craw;
      longint          c;
      longint          th;
      longint          m;
      longint          h;
      lane_result_type r;
      fsum = longint'(s.forget_proj) + longint'(forget_bias);
      rsum = longint'(s.reset_proj) + longint'(reset_bias);
      fpre = clip_q412(fsum);
      rpre = clip_q412(rsum);
      if (fpre != fsum || rpre != rsum) begin
         gate_sat_count++;
      end
      if (s.first_step) begin
         seq_starts++;
         prev = longint'(initial_state);
      end else begin
         prev = longint'(cell_state);
      end
      ft   = sig_lut[lut_bin(fpre)];
      rt   = sig_lut[lut_bin(rpre)];
      craw = longint'(s.candidate) + round_q12((prev - longint'(s.candidate)) * ft);
      c    = clip_q412(craw);
      if (c != craw) begin
         state_sat_count++;
      end
      cell_state = data_type'(c);
      th = tanh_lut[lut_bin(c)];
      m  = round_q12(th * longint'(mask_value));
      h  = clip_q412(longint'(s.sample) + round_q12((m - longint'(s.sample)) * rt));
      r.hidden = data_type'(h);
      r.state  = data_type'(c);
      expected_results.push_back(r);
   endfunction

   task report_mismatch(string msg);
      if (errors < 40) begin
         $display("MISMATCH: %s", msg);
      end
      errors++;
   endtask

   task check_result(logic [RSP_DATA_W-1:0] d);
      lane_result_type want;
      data_type        hidden;
      data_type        state;
      hidden = d[DATA_WIDTH-1:0];
      state  = d[2*DATA_WIDTH-1:DATA_WIDTH];
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result hidden_out=%0d state_out=%0d",
                                   hidden, state));
      end else begin
         want = expected_results.pop_front();
         if (hidden !== want.hidden) begin
            report_mismatch($sformatf("result %0d: hidden_out %0d, expected %0d",
                                      checked, hidden, want.hidden));
         end
         if (state !== want.state) begin
            report_mismatch($sformatf("result %0d: state_out %0d, expected %0d",
                                      checked, state, want.state));
         end
      end
      checked++;
   endtask

   function int pending();
      return expected_results.size();
   endfunction
endclass

module sru_lane_recurrence_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [DATA_WIDTH-1:0]   csr_wdata;

   lane_step_scoreboard sb;
   bit gaps_on = 1'b1;
   int hold_requests = 0;
   int holds_done = 0;
   int settings = 1;

   sru_lane_recurrence_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Timeout with %0d results outstanding.", sb.pending());
      $display("** sru_lane_recurrence_unit: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < hold_requests) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (80) @(negedge clock);
         end else begin
            rsp_tready <= !(gaps_on && $urandom_range(99) < 28);
         end
      end
   end

   function automatic data_type random_q412();
      case ($urandom_range(9))
         0:          return data_type'(DATA_MAX);
         1:          return data_type'(DATA_MIN);
         2, 3, 4, 5: return data_type'($urandom);
         default:    return data_type'(int'($urandom_range(16383)) - 8192);
      endcase
   endfunction

   function automatic lane_step_type make_step(int c, int f, int r, int x, bit first);
      lane_step_type s;
      s.candidate   = data_type'(c);
      s.forget_proj = data_type'(f);
      s.reset_proj  = data_type'(r);
      s.sample      = data_type'(x);
      s.first_step  = first;
      return s;
   endfunction

   task automatic send_step(input lane_step_type s);
      while (gaps_on && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.sample, s.reset_proj, s.forget_proj, s.candidate};
      req_tuser  <= s.first_step;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_step(s);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input data_type v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic set_regs(input data_type fb, input data_type rb,
                           input data_type mv, input data_type is);
      write_reg(CSR_FORGET_BIAS, fb);
      write_reg(CSR_RESET_BIAS, rb);
      write_reg(CSR_MASK_VALUE, mv);
      write_reg(CSR_INITIAL_STATE, is);
      csr_wr_en <= 1'b0;
      settings++;
      @(negedge clock);
   endtask

   initial begin
      lane_step_type s;
      int            n;
      int            seq_len;
      bit            well_formed;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_FORGET_BIAS;
      csr_wdata  = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_step(make_step(32767, 32767, 32767, 32767, 1));
      send_step(make_step(-32768, -32768, -32768, -32768, 0));
      send_step(make_step(4096, 0, 0, -4096, 0));
      send_step(make_step(0, 32767, -32768, 32767, 0));
      send_step(make_step(-32768, -32768, 32767, -32768, 1));
      send_step(make_step(12345, 8192, -8192, -12345, 0));
      drain();

      set_regs(data_type'(DATA_MAX), data_type'(DATA_MIN),
               data_type'(DATA_MIN), data_type'(DATA_MAX));
      send_step(make_step(0, 32767, -32768, 0, 1));
      send_step(make_step(-32768, 100, 32767, 32767, 0));
      send_step(make_step(32767, -32768, 0, -32768, 0));
      send_step(make_step(-32768, 32767, -32768, -32768, 1));
      drain();

      set_regs(data_type'(DATA_MIN), data_type'(DATA_MAX),
               data_type'(DATA_MAX), data_type'(DATA_MIN));
      send_step(make_step(32767, -32768, 32767, -32768, 1));
      send_step(make_step(-32768, 32767, 32767, 32767, 0));
      send_step(make_step(32767, 0, 0, -32768, 0));
      send_step(make_step(0, -1, 1, 0, 1));
      drain();

      set_regs('0, '0, '0, data_type'(4096));
      send_step(make_step(-32768, 0, 32767, 32767, 1));
      send_step(make_step(32767, 32767, 32767, -32768, 0));
      send_step(make_step(-21555, 0, -4096, 21555, 0));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         set_regs(random_q412(), random_q412(), random_q412(), random_q412());
         gaps_on = (phase != 2);
         n = 0;
         while (n < 180) begin
            seq_len     = $urandom_range(24, 1);
            well_formed = ($urandom_range(99) < 80);
            for (int j = 0; j < seq_len && n < 180; j++) begin
               s.candidate   = random_q412();
               s.forget_proj = random_q412();
               s.reset_proj  = random_q412();
               s.sample      = random_q412();
               s.first_step  = well_formed ? (j == 0) : 1'($urandom_range(1));
               if (phase == 3 && n == 60) begin
                  hold_requests++;
               end
               send_step(s);
               n++;
            end
         end
         drain();
      end
      gaps_on = 1'b1;

      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
      end
      $display("Covered %0d steps in %0d register settings, %0d sequence starts.",
               sb.checked, settings, sb.seq_starts);
      $display("Gate sums saturated in %0d steps, cell state in %0d; %0d long output stall.",
               sb.gate_sat_count, sb.state_sat_count, holds_done);
      if (sb.errors == 0) begin
         $display("** sru_lane_recurrence_unit: PASSED **");
      end else begin
         $display("** sru_lane_recurrence_unit: FAILED **");
      end
      $finish;
   end

endmodule
